### hdl/sha256_pkg.sv
// Shared types, constants and round functions of the SHA-256 byte stream hasher.
// Used by the front end, the command queue, the compression core and the top level.
// Depends on nothing.
package sha256_pkg;

	// Default depth of the command queue between front end and core.
	localparam int unsigned CMD_QUEUE_DEPTH = 4;

	// Padding marker byte appended after the last message byte.
	localparam logic [7:0] PAD_BYTE = 8'h80;

	// Number of compression rounds per block.
	localparam int unsigned NUM_ROUNDS = 64;

	// One command from the front end to the compression core.
	typedef struct packed {
		logic        finish;     // emit the digest and restart
		logic        block_end;  // this word is the sixteenth of a block
		logic [31:0] word;       // big-endian message schedule word
	} cmd_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	// Initial hash values.
	function automatic logic [31:0] chain_init(input logic [2:0] idx);
		case (idx)
			3'd0: chain_init = 32'h6a09e667;
			3'd1: chain_init = 32'hbb67ae85;
			3'd2: chain_init = 32'h3c6ef372;
			3'd3: chain_init = 32'ha54ff53a;
			3'd4: chain_init = 32'h510e527f;
			3'd5: chain_init = 32'h9b05688c;
			3'd6: chain_init = 32'h1f83d9ab;
			default: chain_init = 32'h5be0cd19;
		endcase
	endfunction

	// Round constants.
	function automatic logic [31:0] round_k(input logic [5:0] t);
		case (t)
			6'd0:  round_k = 32'h428a2f98;
			6'd1:  round_k = 32'h71374491;
			6'd2:  round_k = 32'hb5c0fbcf;
			6'd3:  round_k = 32'he9b5dba5;
			6'd4:  round_k = 32'h3956c25b;
			6'd5:  round_k = 32'h59f111f1;
			6'd6:  round_k = 32'h923f82a4;
			6'd7:  round_k = 32'hab1c5ed5;
			6'd8:  round_k = 32'hd807aa98;
			6'd9:  round_k = 32'h12835b01;
			6'd10: round_k = 32'h243185be;
			6'd11: round_k = 32'h550c7dc3;
			6'd12: round_k = 32'h72be5d74;
			6'd13: round_k = 32'h80deb1fe;
			6'd14: round_k = 32'h9bdc06a7;
			6'd15: round_k = 32'hc19bf174;
			6'd16: round_k = 32'he49b69c1;
			6'd17: round_k = 32'hefbe4786;
			6'd18: round_k = 32'h0fc19dc6;
			6'd19: round_k = 32'h240ca1cc;
			6'd20: round_k = 32'h2de92c6f;
			6'd21: round_k = 32'h4a7484aa;
			6'd22: round_k = 32'h5cb0a9dc;
			6'd23: round_k = 32'h76f988da;
			6'd24: round_k = 32'h983e5152;
			6'd25: round_k = 32'ha831c66d;
			6'd26: round_k = 32'hb00327c8;
			6'd27: round_k = 32'hbf597fc7;
			6'd28: round_k = 32'hc6e00bf3;
			6'd29: round_k = 32'hd5a79147;
			6'd30: round_k = 32'h06ca6351;
			6'd31: round_k = 32'h14292967;
			6'd32: round_k = 32'h27b70a85;
			6'd33: round_k = 32'h2e1b2138;
			6'd34: round_k = 32'h4d2c6dfc;
			6'd35: round_k = 32'h53380d13;
			6'd36: round_k = 32'h650a7354;
			6'd37: round_k = 32'h766a0abb;
			6'd38: round_k = 32'h81c2c92e;
			6'd39: round_k = 32'h92722c85;
			6'd40: round_k = 32'ha2bfe8a1;
			6'd41: round_k = 32'ha81a664b;
			6'd42: round_k = 32'hc24b8b70;
			6'd43: round_k = 32'hc76c51a3;
			6'd44: round_k = 32'hd192e819;
			6'd45: round_k = 32'hd6990624;
			6'd46: round_k = 32'hf40e3585;
			6'd47: round_k = 32'h106aa070;
			6'd48: round_k = 32'h19a4c116;
			6'd49: round_k = 32'h1e376c08;
			6'd50: round_k = 32'h2748774c;
			6'd51: round_k = 32'h34b0bcb5;
			6'd52: round_k = 32'h391c0cb3;
			6'd53: round_k = 32'h4ed8aa4a;
			6'd54: round_k = 32'h5b9cca4f;
			6'd55: round_k = 32'h682e6ff3;
			6'd56: round_k = 32'h748f82ee;
			6'd57: round_k = 32'h78a5636f;
			6'd58: round_k = 32'h84c87814;
			6'd59: round_k = 32'h8cc70208;
			6'd60: round_k = 32'h90befffa;
			6'd61: round_k = 32'ha4506ceb;
			6'd62: round_k = 32'hbef9a3f7;
			default: round_k = 32'hc67178f2;
		endcase
	endfunction

endpackage

### hdl/sha256_if.sv
// Valid/ready channel interfaces for message bytes in and digest words out.
// Standalone; used by the top level, the front end, the core and the checker binding.
interface sha256_msg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       end_of_message;

	modport source(output valid, data_byte, byte_present, end_of_message, input ready);
	modport sink(input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha256_digest_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source(output valid, digest_word, word_index, last_word, input ready);
	modport sink(input valid, digest_word, word_index, last_word, output ready);
endinterface

### hdl/sha256_front.sv
// Front end: takes message bytes, packs them into big-endian words, counts the length
// and generates the padding and length words. Depends on sha256_pkg and sha256_msg_if.
module sha256_front (
	input  logic               clk,
	input  logic               arst_n,
	sha256_msg_if.sink         msg,
	output sha256_pkg::cmd_t   cmd,
	output logic               cmd_valid,
	input  logic               cmd_ready
);
	import sha256_pkg::*;

	localparam logic [1:0] F_IN  = 2'd0;
	localparam logic [1:0] F_PAD = 2'd1;
	localparam logic [1:0] F_FIN = 2'd2;

	logic [1:0]  state_q;
	logic [31:0] word_q;
	logic [5:0]  cnt_q;
	logic [60:0] total_q;
	logic [3:0]  wi_q;
	logic        first_q;
	logic        len_ok_q;

	logic        acc;
	logic [5:0]  cnt_next;
	logic [31:0] ins_word;
	logic [31:0] pad_word;
	logic [63:0] bit_len;

	// Items are taken only while gathering and when the queue has room.
	assign msg.ready = (state_q == F_IN) && cmd_ready;
	assign acc       = msg.valid && msg.ready;
	assign cnt_next  = cnt_q + 6'(msg.byte_present);
	assign bit_len   = {total_q, 3'b000};

	// Insert the new byte at its big-endian position in the partial word.
	always_comb begin
		case (cnt_q[1:0])
			2'd0: ins_word = {msg.data_byte, word_q[23:0]};
			2'd1: ins_word = {word_q[31:24], msg.data_byte, word_q[15:0]};
			2'd2: ins_word = {word_q[31:16], msg.data_byte, word_q[7:0]};
			default: ins_word = {word_q[31:8], msg.data_byte};
		endcase
	end

	// First padding word: kept bytes, the marker byte, then zeros.
	always_comb begin
		case (cnt_q[1:0])
			2'd0: pad_word = {PAD_BYTE, 24'h0};
			2'd1: pad_word = {word_q[31:24], PAD_BYTE, 16'h0};
			2'd2: pad_word = {word_q[31:16], PAD_BYTE, 8'h0};
			default: pad_word = {word_q[31:8], PAD_BYTE};
		endcase
	end

	// Command toward the core.
	always_comb begin
		cmd       = '0;
		cmd_valid = 1'b0;
		case (state_q)
			F_IN: begin
				cmd_valid     = acc && msg.byte_present && (cnt_q[1:0] == 2'd3);
				cmd.word      = ins_word;
				cmd.block_end = (cnt_q[5:2] == 4'd15);
			end
			F_PAD: begin
				cmd_valid     = 1'b1;
				cmd.block_end = (wi_q == 4'd15);
				if (first_q) begin
					cmd.word = pad_word;
				end else if (len_ok_q && (wi_q == 4'd14)) begin
					cmd.word = bit_len[63:32];
				end else if (len_ok_q && (wi_q == 4'd15)) begin
					cmd.word = bit_len[31:0];
				end else begin
					cmd.word = '0;
				end
			end
			F_FIN: begin
				cmd_valid  = 1'b1;
				cmd.finish = 1'b1;
			end
			default: begin
				cmd_valid = 1'b0;
			end
		endcase
	end

	// Partial word register; payload only.
	always_ff @(posedge clk) begin
		if (acc && msg.byte_present) begin
			word_q <= ins_word;
		end
	end

	// Byte counting and padding sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= F_IN;
			cnt_q    <= '0;
			total_q  <= '0;
			wi_q     <= '0;
			first_q  <= 1'b0;
			len_ok_q <= 1'b0;
		end else begin
			case (state_q)
				F_IN: begin
					if (acc && msg.byte_present) begin
						cnt_q   <= cnt_next;
						total_q <= total_q + 61'd1;
					end
					if (acc && msg.end_of_message) begin
						state_q  <= F_PAD;
						wi_q     <= cnt_next[5:2];
						first_q  <= 1'b1;
						len_ok_q <= (cnt_next <= 6'd55);
					end
				end
				F_PAD: begin
					if (cmd_ready) begin
						first_q <= 1'b0;
						wi_q    <= wi_q + 4'd1;
						if (wi_q == 4'd15) begin
							if (len_ok_q) begin
								state_q <= F_FIN;
							end else begin
								len_ok_q <= 1'b1;
							end
						end
					end
				end
				F_FIN: begin
					if (cmd_ready) begin
						state_q <= F_IN;
						cnt_q   <= '0;
						total_q <= '0;
					end
				end
				default: begin
					state_q <= F_IN;
				end
			endcase
		end
	end

endmodule

### hdl/sha256_queue.sv
// Short command queue that decouples the front end from the compression core.
// Depends on sha256_pkg.
module sha256_queue #(
	parameter int unsigned DEPTH = sha256_pkg::CMD_QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  sha256_pkg::cmd_t push_cmd,
	input  logic             push_valid,
	output logic             push_ready,
	output sha256_pkg::cmd_t pop_cmd,
	output logic             pop_valid,
	input  logic             pop_ready
);
	import sha256_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	cmd_t             entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = entries_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

### hdl/sha256_core.sv
// Compression core: loads sixteen schedule words, runs one round per cycle, folds the
// result into the chaining words and sends out the digest. Depends on sha256_pkg and sha256_digest_if.
module sha256_core (
	input  logic             clk,
	input  logic             arst_n,
	input  sha256_pkg::cmd_t cmd,
	input  logic             cmd_valid,
	output logic             cmd_ready,
	sha256_digest_if.source  digest
);
	import sha256_pkg::*;

	localparam logic [1:0] B_LOAD  = 2'd0;
	localparam logic [1:0] B_ROUND = 2'd1;
	localparam logic [1:0] B_ADD   = 2'd2;
	localparam logic [1:0] B_OUT   = 2'd3;

	logic [1:0]  state_q;
	logic [5:0]  rnd_q;
	logic [2:0]  oidx_q;
	logic        out_valid_q;
	logic [31:0] out_word_q;
	logic [2:0]  out_index_q;
	logic        out_last_q;
	logic [31:0] chain_q [8];
	logic [31:0] w_q [16];
	logic [31:0] v_q [8];

	logic        cmd_take;
	logic        out_load;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] w_new;
	logic [31:0] ch;
	logic [31:0] maj;

	assign cmd_ready = (state_q == B_LOAD);
	assign cmd_take  = cmd_valid && cmd_ready;
	assign out_load  = (state_q == B_OUT) && (!out_valid_q || digest.ready);

	assign digest.valid       = out_valid_q;
	assign digest.digest_word = out_word_q;
	assign digest.word_index  = out_index_q;
	assign digest.last_word   = out_last_q;

	// One compression round and the next schedule word.
	always_comb begin
		ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1    = v_q[7] + big_sigma1(v_q[4]) + ch + round_k(rnd_q) + w_q[0];
		t2    = big_sigma0(v_q[0]) + maj;
		w_new = small_sigma1(w_q[14]) + w_q[9] + small_sigma0(w_q[1]) + w_q[0];
	end

	// Schedule shift line, round variables and output payload.
	always_ff @(posedge clk) begin
		if (state_q == B_LOAD && cmd_take && !cmd.finish) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= cmd.word;
			if (cmd.block_end) begin
				for (int i = 0; i < 8; i++) begin
					v_q[i] <= chain_q[i];
				end
			end
		end else if (state_q == B_ROUND) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= w_new;
			v_q[7]  <= v_q[6];
			v_q[6]  <= v_q[5];
			v_q[5]  <= v_q[4];
			v_q[4]  <= v_q[3] + t1;
			v_q[3]  <= v_q[2];
			v_q[2]  <= v_q[1];
			v_q[1]  <= v_q[0];
			v_q[0]  <= t1 + t2;
		end
		if (out_load) begin
			out_word_q  <= chain_q[oidx_q];
			out_index_q <= oidx_q;
			out_last_q  <= (oidx_q == 3'd7);
		end
	end

	// Sequencer, chaining words and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_LOAD;
			rnd_q       <= '0;
			oidx_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= chain_init(3'(i));
			end
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (digest.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_LOAD: begin
					if (cmd_take) begin
						if (cmd.finish) begin
							state_q <= B_OUT;
							oidx_q  <= '0;
						end else if (cmd.block_end) begin
							state_q <= B_ROUND;
							rnd_q   <= '0;
						end
					end
				end
				B_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'(NUM_ROUNDS - 1)) begin
						state_q <= B_ADD;
					end
				end
				B_ADD: begin
					for (int i = 0; i < 8; i++) begin
						chain_q[i] <= chain_q[i] + v_q[i];
					end
					state_q <= B_LOAD;
				end
				B_OUT: begin
					if (out_load) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							state_q <= B_LOAD;
							for (int i = 0; i < 8; i++) begin
								chain_q[i] <= chain_init(3'(i));
							end
						end
					end
				end
				default: begin
					state_q <= B_LOAD;
				end
			endcase
		end
	end

endmodule

### hdl/sha256_byte_stream_hasher.sv
// SHA-256 over a byte stream: one message byte per transfer, eight digest words out.
// Throughput: one byte per cycle while gathering and the queue has room; the default
// four-entry queue fills while the core runs the rounds and the add step of a block, which
// holds off further bytes until the core takes commands again.
// Reset is asynchronous, active low, and restores the initial hash values with an empty block.
module sha256_byte_stream_hasher #(
	parameter int unsigned QUEUE_DEPTH = sha256_pkg::CMD_QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	sha256_msg_if.sink      msg,
	sha256_digest_if.source digest
);
	import sha256_pkg::*;

	cmd_t front_cmd;
	logic front_valid;
	logic front_ready;
	cmd_t core_cmd;
	logic core_valid;
	logic core_ready;

	// Byte packing, length count and padding.
	sha256_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg       (msg),
		.cmd       (front_cmd),
		.cmd_valid (front_valid),
		.cmd_ready (front_ready)
	);

	// Decoupling queue.
	sha256_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_cmd   (front_cmd),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.pop_cmd    (core_cmd),
		.pop_valid  (core_valid),
		.pop_ready  (core_ready)
	);

	// Compression and digest output.
	sha256_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (core_cmd),
		.cmd_valid (core_valid),
		.cmd_ready (core_ready),
		.digest    (digest)
	);

endmodule

### hdl/sha256_checker.sv
// Port-level checker for the SHA-256 byte stream hasher and its bind statement.
// Depends only on the top level's ports.
module sha256_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        msg_valid,
	input logic        msg_ready,
	input logic        msg_eom,
	input logic        dig_valid,
	input logic        dig_ready,
	input logic [31:0] dig_word,
	input logic [2:0]  dig_index,
	input logic        dig_last
);
	logic [2:0] exp_idx_q;
	logic [3:0] pending_q;
	logic       fin_in;
	logic       last_out;

	assign fin_in   = msg_valid && msg_ready && msg_eom;
	assign last_out = dig_valid && dig_ready && dig_last;

	// Expected word position and number of finishes still owed a digest.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_idx_q <= '0;
			pending_q <= '0;
		end else begin
			if (dig_valid && dig_ready) begin
				exp_idx_q <= exp_idx_q + 3'd1;
			end
			if (fin_in && !last_out) begin
				pending_q <= pending_q + 4'd1;
			end else if (last_out && !fin_in) begin
				pending_q <= pending_q - 4'd1;
			end
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid && !dig_ready |=> dig_valid && $stable(dig_word) &&
			$stable(dig_index) && $stable(dig_last))
		else $error("digest transfer changed while stalled");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid |-> (dig_last == (dig_index == 3'd7)))
		else $error("last word flag does not match word position");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid && dig_ready |-> dig_index == exp_idx_q)
		else $error("digest words out of order");

	a_owed: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid |-> pending_q != 4'd0)
		else $error("digest word without a finished message");

endmodule

bind sha256_byte_stream_hasher sha256_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.msg_valid (msg.valid),
	.msg_ready (msg.ready),
	.msg_eom   (msg.end_of_message),
	.dig_valid (digest.valid),
	.dig_ready (digest.ready),
	.dig_word  (digest.digest_word),
	.dig_index (digest.word_index),
	.dig_last  (digest.last_word)
);
